FILE: rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and codes for the rational accumulator: the sequencer states,
// the request command codes and the operation select of the shared adder.
// ----------------------------------------------------------------------------
package rar_pkg;

   // Request commands.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   // Operation of the shared adder/subtractor.
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Sequencer states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL1 = 9'b000000010,
      ST_MUL2 = 9'b000000100,
      ST_MUL3 = 9'b000001000,
      ST_SUM  = 9'b000010000,
      ST_GCD  = 9'b000100000,
      ST_DIVN = 9'b001000000,
      ST_DIVD = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

endpackage

FILE: rtl/core/rar_alu.sv
// ----------------------------------------------------------------------------
// rar_alu
// Shared adder/subtractor of the rational accumulator. The carry out is set
// on a subtraction when op_a >= op_b, so it doubles as the magnitude compare.
// ----------------------------------------------------------------------------
module rar_alu #(
   parameter int WIDTH = 65
) (
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   input  rar_pkg::alu_op_type  op,
   output logic [WIDTH-1:0]     result,
   output logic                 carry
);
   import rar_pkg::*;

   logic [WIDTH-1:0] b_eff;
   logic [WIDTH:0]   sum;

   // Subtraction is addition of the inverted operand with a carry in.
   always_comb begin
      b_eff  = (op == ALU_SUB) ? ~op_b : op_b;
      sum    = {1'b0, op_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (op == ALU_SUB)};
      result = sum[WIDTH-1:0];
      carry  = sum[WIDTH];
   end

endmodule

FILE: rtl/core/rational_accumulator_reduce.sv
// A load goes straight to the binary GCD and the two divisions; an add first forms the
// cross products and their signed sum, swapping once when, with unlike signs, the smaller comes first.
// Throughput: one request at a time; the shared adder/subtractor does the GCD
// steps and both restoring divisions, the divisions one quotient bit per cycle.
// A finished response waits in an output register while the next request runs.
// Reset: synchronous, active high; the running value becomes 0/1.
// ----------------------------------------------------------------------------
// rational_accumulator_reduce
// Keeps a running fraction in lowest terms. Each request loads or adds a
// fraction; the result is reduced by a binary GCD and two long divisions.
// ----------------------------------------------------------------------------
module rational_accumulator_reduce #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_in_num,
   input  logic [31:0] req_in_den,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sum_num_out,
   output logic [31:0] rsp_sum_den_out,
   output logic        rsp_overflow
);
   import rar_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int DW = 2 * VALUE_WIDTH;
   localparam int RW = DW + 1;
   localparam int CW = $clog2(DW);

   state_type state_ff, state_in;

   // Captured request operands.
   logic [W-1:0]  in_mag_ff, in_mag_in;
   logic          in_neg_ff, in_neg_in;
   logic [W-1:0]  in_den_ff, in_den_in;

   // Running value, sign and magnitude.
   logic          acc_neg_ff, acc_neg_in;
   logic [W-1:0]  acc_mag_ff, acc_mag_in;
   logic [W-1:0]  acc_den_ff, acc_den_in;

   // Working registers.
   logic [DW-1:0] a_ff, a_in;
   logic [DW-1:0] b_ff, b_in;
   logic [DW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_num_ff, rsp_num_in;
   logic [31:0]   rsp_den_ff, rsp_den_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // Shared units.
   logic [W-1:0]  mul_a, mul_b;
   logic [DW-1:0] mul_p;
   logic [RW-1:0] alu_a, alu_b, alu_res;
   alu_op_type    alu_op;
   logic          alu_carry;

   // Combinational helpers.
   logic [W-1:0]  req_num_w, req_den_w, req_mag;
   logic          req_neg;
   logic [RW-1:0] div_t;
   logic [DW-1:0] div_q;
   logic [W-1:0]  lim;
   logic          fin_neg, fin_ovf, out_neg;
   logic [W-1:0]  out_mag, out_num, out_den;
   logic          req_fire, rsp_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_num_out = rsp_num_ff;
   assign rsp_sum_den_out = rsp_den_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // Split the incoming numerator into sign and magnitude; a zero denominator is one.
   always_comb begin
      req_num_w = req_in_num[W-1:0];
      req_neg   = req_num_w[W-1];
      req_mag   = req_neg ? (~req_num_w + W'(1)) : req_num_w;
      req_den_w = (req_in_den[W-1:0] == '0) ? W'(1) : req_in_den[W-1:0];
   end

   // The one multiplier, shared by the three cross products.
   always_comb begin
      case (state_ff)
         ST_MUL1: begin
            mul_a = acc_mag_ff;
            mul_b = in_den_ff;
         end
         ST_MUL2: begin
            mul_a = in_mag_ff;
            mul_b = acc_den_ff;
         end
         default: begin
            mul_a = acc_den_ff;
            mul_b = in_den_ff;
         end
      endcase
      mul_p = DW'(mul_a) * DW'(mul_b);
   end

   // Operand select for the shared adder/subtractor.
   always_comb begin
      div_t = (state_ff == ST_DIVD) ? {rem_ff, den_ff[DW-1]} : {rem_ff, num_ff[DW-1]};
      case (state_ff)
         ST_SUM: begin
            alu_a  = {1'b0, a_ff};
            alu_b  = {1'b0, b_ff};
            alu_op = (in_neg_ff == acc_neg_ff) ? ALU_ADD : ALU_SUB;
         end
         ST_DIVN, ST_DIVD: begin
            alu_a  = div_t;
            alu_b  = {1'b0, b_ff};
            alu_op = ALU_SUB;
         end
         default: begin
            alu_a  = {1'b0, a_ff};
            alu_b  = {1'b0, b_ff};
            alu_op = ALU_SUB;
         end
      endcase
   end

   rar_alu #(
      .WIDTH (RW)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op     (alu_op),
      .result (alu_res),
      .carry  (alu_carry)
   );

   // Range check of the reduced value and the response value.
   always_comb begin
      fin_neg = neg_ff && (num_ff != '0);
      lim     = fin_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      fin_ovf = (num_ff[DW-1:W] != '0) || (num_ff[W-1:0] > lim) || (den_ff[DW-1:W] != '0);
      out_neg = fin_ovf ? acc_neg_ff : fin_neg;
      out_mag = fin_ovf ? acc_mag_ff : num_ff[W-1:0];
      out_den = fin_ovf ? acc_den_ff : den_ff[W-1:0];
      out_num = out_neg ? (~out_mag + W'(1)) : out_mag;
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      in_mag_in    = in_mag_ff;
      in_neg_in    = in_neg_ff;
      in_den_in    = in_den_ff;
      acc_neg_in   = acc_neg_ff;
      acc_mag_in   = acc_mag_ff;
      acc_den_in   = acc_den_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      div_q        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               in_mag_in = req_mag;
               in_neg_in = req_neg;
               in_den_in = req_den_w;
               if (req_command == CMD_LOAD) begin
                  a_in     = DW'(req_mag);
                  num_in   = DW'(req_mag);
                  b_in     = DW'(req_den_w);
                  den_in   = DW'(req_den_w);
                  neg_in   = req_neg;
                  state_in = ST_GCD;
               end else begin
                  neg_in   = acc_neg_ff;
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            a_in     = mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            b_in     = mul_p;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            den_in   = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // Unlike signs with the smaller first: swap once, sign follows the input.
            if (alu_op == ALU_SUB && !alu_carry) begin
               a_in   = b_ff;
               b_in   = a_ff;
               neg_in = in_neg_ff;
            end else begin
               a_in     = alu_res[DW-1:0];
               num_in   = alu_res[DW-1:0];
               b_in     = den_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // Binary GCD; common factors of two are stripped from num and den too.
            if (a_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CW'(DW - 1);
               state_in = ST_DIVN;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in   = a_ff >> 1;
               b_in   = b_ff >> 1;
               num_in = num_ff >> 1;
               den_in = den_ff >> 1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (alu_carry) begin
               a_in = alu_res[DW:1];
            end else begin
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         ST_DIVN, ST_DIVD: begin
            // Restoring division by the GCD held in b, one quotient bit a cycle.
            rem_in = alu_carry ? alu_res[DW-1:0] : div_t[DW-1:0];
            if (state_ff == ST_DIVN) begin
               div_q  = {num_ff[DW-2:0], alu_carry};
               num_in = div_q;
            end else begin
               div_q  = {den_ff[DW-2:0], alu_carry};
               den_in = div_q;
            end
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = CW'(DW - 1);
               state_in = (state_ff == ST_DIVN) ? ST_DIVD : ST_FIN;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_FIN: begin
            // Store the reduced value if it fits, then hand over the response.
            if (!rsp_valid_ff || rsp_ready) begin
               if (!fin_ovf) begin
                  acc_neg_in = fin_neg;
                  acc_mag_in = num_ff[W-1:0];
                  acc_den_in = den_ff[W-1:0];
               end
               rsp_valid_in = 1'b1;
               rsp_num_in   = 32'($signed(out_num));
               rsp_den_in   = 32'(out_den);
               rsp_ovf_in   = fin_ovf;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and running-value registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_neg_ff   <= 1'b0;
         acc_mag_ff   <= '0;
         acc_den_ff   <= W'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         acc_neg_ff   <= acc_neg_in;
         acc_mag_ff   <= acc_mag_in;
         acc_den_ff   <= acc_den_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_mag_ff  <= in_mag_in;
      in_neg_ff  <= in_neg_in;
      in_den_ff  <= in_den_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // The GCD loop never works against a zero divisor.
   a_gcd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> (b_ff != '0))
      else $error("GCD divisor register is zero");

   // The running denominator stays positive.
   a_acc_den: assert property (@(posedge clock) disable iff (reset)
      acc_den_ff != '0)
      else $error("running denominator is zero");

   // A pending response always shows the denominator of the running value.
   a_rsp_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_den_ff == 32'(acc_den_ff)))
      else $error("response denominator differs from running value");

endmodule

FILE: tb/tb_rational_accumulator_reduce.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_accumulator_reduce
// Self-checking bench for the running-fraction accumulator. A directed set of
// loads and adds covers zero denominators, zero sums, sign cancellation and
// overflow at both ends of the range. Random load-then-add sequences follow,
// with some unrelated requests mixed in. A scoreboard keeps its own copy of
// the running fraction and checks every response in order. Random idle cycles
// are inserted on both the request and the response side.
// ----------------------------------------------------------------------------
module tb_rational_accumulator_reduce;
   import rar_pkg::*;

   localparam int VALUE_WIDTH   = 32;
   localparam int RANDOM_ITEMS  = 1925;
   localparam int IDLE_LIMIT    = 8000;
   localparam int SETTLE_CYCLES = 10 * VALUE_WIDTH + 40;

   // Scoreboard: tracks the running fraction and queues the expected responses.
   class fraction_scoreboard #(int W = 32);
      typedef bit [63:0] wide_type;
      typedef struct packed {
         bit [31:0] num;
         bit [31:0] den;
         bit        overflow;
      } fraction_type;

      localparam wide_type VMASK = (64'd1 << W) - 64'd1;

      bit [31:0] run_num;
      bit [31:0] run_den;
      fraction_type expected_q[$];
      int errors;

      function new();
         run_num = '0;
         run_den = 32'd1;
         errors  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%0t: %s", $realtime, msg);
         end
      endfunction

      // Split a W-bit two's complement value into sign and magnitude.
      function wide_type magnitude(bit [31:0] v, output bit neg);
         wide_type m;
         m   = wide_type'(v) & VMASK;
         neg = m[W-1];
         return neg ? ((~m + 64'd1) & VMASK) : m;
      endfunction

      function wide_type euclid(wide_type a, wide_type b);
         wide_type t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // Reduce the fraction and store it only when it fits in W bits.
      function bit reduce_commit(bit neg, wide_type mag, wide_type den);
         wide_type g;
         wide_type lim;
         wide_type v;
         g = euclid(mag, den);
         if (g == 0) begin
            g = 64'd1;
         end
         mag = mag / g;
         den = den / g;
         if (mag == 0) begin
            neg = 1'b0;
            den = 64'd1;
         end
         lim = 64'd1 << (W - 1);
         if (!neg) begin
            lim = lim - 64'd1;
         end
         if (mag > lim || den > VMASK) begin
            return 1'b0;
         end
         v       = neg ? (64'd0 - mag) : mag;
         run_num = v[31:0];
         run_den = den[31:0];
         return 1'b1;
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(bit cmd, bit [31:0] num, bit [31:0] den);
         bit           in_neg;
         bit           acc_neg;
         bit           neg;
         bit           fits;
         wide_type     in_mag;
         wide_type     in_d;
         wide_type     acc_mag;
         wide_type     acc_d;
         wide_type     p1;
         wide_type     p2;
         wide_type     mag;
         fraction_type res;
         in_mag = magnitude(num, in_neg);
         in_d   = wide_type'(den) & VMASK;
         if (in_d == 0) begin
            in_d = 64'd1;
         end
         if (cmd == CMD_LOAD) begin
            fits = reduce_commit(in_neg, in_mag, in_d);
         end else begin
            acc_mag = magnitude(run_num, acc_neg);
            acc_d   = wide_type'(run_den);
            p1      = acc_mag * in_d;
            p2      = in_mag * acc_d;
            // Signed sum of the cross products in sign-magnitude form.
            if (acc_neg == in_neg) begin
               mag = p1 + p2;
               neg = acc_neg;
            end else if (p1 >= p2) begin
               mag = p1 - p2;
               neg = acc_neg;
            end else begin
               mag = p2 - p1;
               neg = in_neg;
            end
            fits = reduce_commit(neg, mag, acc_d * in_d);
         end
         res.num      = run_num;
         res.den      = run_den;
         res.overflow = !fits;
         expected_q.push_back(res);
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(logic [31:0] num, logic [31:0] den, logic ovf);
         fraction_type want;
         if (expected_q.size() == 0) begin
            flag($sformatf("response %0d/%0d ovf=%b with no request outstanding",
                           $signed(num), den, ovf));
            return;
         end
         want = expected_q.pop_front();
         if (num !== want.num || den !== want.den || ovf !== want.overflow) begin
            flag($sformatf("mismatch: expected %0d/%0d ovf=%b, got %0d/%0d ovf=%b",
                           $signed(want.num), want.den, want.overflow,
                           $signed(num), den, ovf));
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_command = CMD_LOAD;
   logic [31:0] req_in_num  = '0;
   logic [31:0] req_in_den  = '0;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_sum_num_out;
   logic [31:0] rsp_sum_den_out;
   logic        rsp_overflow;

   fraction_scoreboard #(VALUE_WIDTH) board;

   rational_accumulator_reduce #(
      .VALUE_WIDTH     (VALUE_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_in_num      (req_in_num),
      .req_in_den      (req_in_den),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sum_num_out (rsp_sum_num_out),
      .rsp_sum_den_out (rsp_sum_den_out),
      .rsp_overflow    (rsp_overflow)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 400);
   endfunction

   // Drive one request and hold it until the block takes it.
   task automatic send_request(bit cmd, bit [31:0] num, bit [31:0] den, bit no_gap);
      int gap;
      gap = no_gap ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_in_num  <= num;
      req_in_den  <= den;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(cmd, num, den);
   endtask

   // Request with a numerator and denominator drawn from mixed magnitude classes.
   task automatic send_random(bit cmd, bit no_gap);
      bit [31:0] num;
      bit [31:0] den;
      bit [31:0] f;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: num = 32'($urandom_range(0, 128)) - 32'd64;
         4, 5:       num = 32'($urandom_range(0, 65536)) - 32'd32768;
         6, 7, 8:    num = $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0:       num = 32'd0;
               1:       num = 32'd1;
               2:       num = 32'hFFFF_FFFF;
               3:       num = 32'h7FFF_FFFF;
               default: num = 32'h8000_0000;
            endcase
         end
      endcase
      case ($urandom_range(0, 9))
         0:          den = 32'd0;
         1, 2, 3, 4: den = $urandom_range(1, 64);
         5, 6:       den = $urandom_range(1, 65536);
         7, 8:       den = $urandom;
         default: begin
            case ($urandom_range(0, 2))
               0:       den = 32'd1;
               1:       den = 32'hFFFF_FFFF;
               default: den = 32'h8000_0000;
            endcase
         end
      endcase
      // A common factor gives the reduction something to remove.
      if (den != 0 && den <= 64 && $urandom_range(0, 2) == 0) begin
         f   = $urandom_range(2, 30);
         num = num * f;
         den = den * f;
      end
      send_request(cmd, num, den, no_gap);
   endtask

   // Response side: random stalls, with long stretches of steady ready.
   initial begin : rsp_stall_driver
      int hold;
      int run;
      @(posedge clock);
      forever begin
         hold = idle_length();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 8);
         repeat (run) @(posedge clock);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         board.check_response(rsp_sum_num_out, rsp_sum_den_out, rsp_overflow);
      end
   end

   // Watchdog: ends the run when no handshake happens for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Main sequence: reset, directed requests, random sequences, drain.
   initial begin : stimulus
      int sent;
      int adds;
      bit no_gap;
      bit paused;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed requests.
      send_request(CMD_ADD,  32'd5,          32'd0,          1'b0); // add to 0/1, zero den
      send_request(CMD_LOAD, 32'd0,          32'd7,          1'b0); // zero numerator
      send_request(CMD_LOAD, 32'hFFFF_FFFA,  32'd4,          1'b0); // -6/4 -> -3/2
      send_request(CMD_ADD,  32'd3,          32'd2,          1'b0); // cancels to zero
      send_request(CMD_LOAD, 32'h7FFF_FFFF,  32'd1,          1'b0);
      send_request(CMD_ADD,  32'd1,          32'd1,          1'b0); // positive overflow
      send_request(CMD_LOAD, 32'h8000_0000,  32'd0,          1'b0); // most negative
      send_request(CMD_ADD,  32'hFFFF_FFFF,  32'd1,          1'b0); // negative overflow
      send_request(CMD_ADD,  32'd1,          32'd1,          1'b0);
      send_request(CMD_LOAD, 32'd1,          32'hFFFF_FFFF,  1'b0);
      send_request(CMD_ADD,  32'd1,          32'hFFFF_FFFE,  1'b0); // denominator too wide
      send_request(CMD_LOAD, 32'h8000_0000,  32'd2,          1'b0);
      send_request(CMD_LOAD, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
      send_request(CMD_ADD,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0);
      send_request(CMD_LOAD, 32'h7FFF_FFFF,  32'h7FFF_FFFF,  1'b0); // reduces to 1/1
      send_request(CMD_ADD,  32'hFFFF_FFFD,  32'd4,          1'b0); // mixed signs, acc larger
      send_request(CMD_ADD,  32'hFFFF_FFFF,  32'd2,          1'b0); // mixed signs, input larger
      send_request(CMD_LOAD, 32'd12,         32'd18,         1'b0);
      send_request(CMD_ADD,  32'h8000_0000,  32'hFFFF_FFFF,  1'b0);
      send_request(CMD_LOAD, 32'h8000_0000,  32'h8000_0000,  1'b0);
      send_request(CMD_ADD,  32'h8000_0000,  32'd1,          1'b0);
      send_request(CMD_LOAD, 32'd0,          32'd0,          1'b0);
      send_request(CMD_ADD,  32'd0,          32'd0,          1'b0);
      send_request(CMD_ADD,  32'h5555_5555,  32'hAAAA_AAAA,  1'b0);

      // Random part: mostly a load followed by a run of adds.
      sent   = 0;
      no_gap = 1'b0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 50 == 0) begin
            no_gap = ($urandom_range(0, 3) == 0);
         end
         // Once, let the block drain completely before going on.
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.pending() != 0) @(posedge clock);
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(1'($urandom_range(0, 1)), $urandom, $urandom, no_gap);
            sent++;
         end else begin
            send_random(CMD_LOAD, no_gap);
            adds = $urandom_range(1, 8);
            repeat (adds) send_random(CMD_ADD, no_gap);
            sent += adds + 1;
         end
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray response.
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
